// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ngga_pkg.sv -----
// Types and constants of the GGA position parser.
package ngga_pkg;

    // Characters the parser reacts to
    localparam logic [7:0] CHR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_POINT   = 8'h2E;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_G       = 8'h47;

    // Position of the talker/type character that must be 'G'
    localparam int TYPE_CHAR_POS   = 3;
    // Lowest byte index accepted for the third comma
    localparam int THIRD_COMMA_MIN = 17;

    // Comma counts that select a field
    localparam logic [2:0] COMMA_LAT = 3'd2;
    localparam logic [2:0] COMMA_NS  = 3'd3;
    localparam logic [2:0] COMMA_LON = 3'd4;
    localparam logic [2:0] COMMA_EW  = 3'd5;
    localparam logic [2:0] COMMA_MAX = 3'd7;

    // Number reading window and phases
    localparam logic [3:0] WINDOW_LEN  = 4'd9;
    localparam logic [3:0] PHASE_INT   = 4'd0;
    localparam logic [3:0] PHASE_FRAC  = 4'd1;
    localparam logic [3:0] FRAC_DIGITS = 4'd4;
    localparam logic [3:0] PHASE_DONE  = 4'd15;

    // Coordinate width and the position shown before the first fix
    localparam int COORD_W = 44;
    localparam logic [COORD_W-1:0] HELD_LAT_RST = 44'd34350000;
    localparam logic [COORD_W-1:0] HELD_LON_RST = 44'd113380000;
    localparam logic [7:0]         HELD_NS_RST  = 8'h4E;
    localparam logic [7:0]         HELD_EW_RST  = 8'h45;

    typedef logic [COORD_W-1:0] coord_t;

    // Weight of one digit at a given power of ten (0..4)
    function automatic logic [16:0] digit_weight(input logic [3:0] d, input logic [2:0] k);
        logic [16:0] dw;
        dw = {13'd0, d};
        case (k)
            3'd0:    digit_weight = dw;
            3'd1:    digit_weight = 17'(dw * 17'd10);
            3'd2:    digit_weight = 17'(dw * 17'd100);
            3'd3:    digit_weight = 17'(dw * 17'd1000);
            default: digit_weight = 17'(dw * 17'd10000);
        endcase
    endfunction

    // Multiply a coordinate by ten with two shifts and an add
    function automatic coord_t times_ten(input coord_t x);
        times_ten = {x[COORD_W-4:0], 3'b000} + {x[COORD_W-2:0], 1'b0};
    endfunction

endpackage

// ----- rtl/core/nmea_gga_position_parser_unit.sv -----
// Top level of the GGA position parser: byte register, parse step, result register.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+-------------------------------
//  input   | s_valid s_ready s_rx_byte               | one received character a word
//  result  | m_valid m_ready m_fix_valid             | one position word per GGA line
//          | m_latitude_micro m_longitude_micro      |
//          | m_north_south m_east_west               |
//
// One character per cycle while no newline waits on a full result register. A newline
// enters the byte register, its result then the result register. The accumulator keeps
// the value already scaled by 10^4, so each integer digit costs one multiply-by-ten add
// and each fraction digit one add; the newline path selects held or pending values.
// Reset (aresetn low, synchronous) closes any frame and loads the default position.
// A newline that yields a result waits in the byte register while the result register
// is full and m_ready is low; every other character keeps moving under a stalled result.
`include "assert_macros.svh"

module nmea_gga_position_parser_unit
    import ngga_pkg::*;
#(
    parameter int BUFFER_BYTES = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_fix_valid,
    output logic [COORD_W-1:0] m_latitude_micro,
    output logic [COORD_W-1:0] m_longitude_micro,
    output logic [7:0]         m_north_south,
    output logic [7:0]         m_east_west
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);

    // Input byte register
    logic       byte_valid_reg;
    logic [7:0] rx_byte_reg;

    // Frame state
    logic             in_frame_reg,       in_frame_next;
    logic [CNT_W-1:0] stored_count_reg,   stored_count_next;
    logic [2:0]       comma_count_reg,    comma_count_next;
    logic [3:0]       window_pos_reg,     window_pos_next;
    coord_t           scaled_accum_reg,   scaled_accum_next;
    logic [3:0]       number_phase_reg,   number_phase_next;
    logic             type_is_g_reg,      type_is_g_next;
    logic             third_comma_ok_reg, third_comma_ok_next;
    coord_t           pending_lat_reg,    pending_lat_next;
    coord_t           pending_lon_reg,    pending_lon_next;
    logic [7:0]       pending_ns_reg,     pending_ns_next;
    logic [7:0]       pending_ew_reg,     pending_ew_next;
    coord_t           held_lat_reg,       held_lat_next;
    coord_t           held_lon_reg,       held_lon_next;
    logic [7:0]       held_ns_reg,        held_ns_next;
    logic [7:0]       held_ew_reg,        held_ew_next;

    // Result register
    logic       m_valid_reg;
    logic       fix_valid_reg;
    coord_t     lat_out_reg;
    coord_t     lon_out_reg;
    logic [7:0] ns_out_reg;
    logic [7:0] ew_out_reg;

    logic emit;
    logic fix_valid_now;
    logic advance;

    // Let the byte go unless it makes a result while the result register is full and m_ready is low
    assign advance = byte_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign s_ready = !byte_valid_reg || advance;

    // Process the registered byte
    always_comb begin : parse_step
        logic [3:0] digit;
        logic       is_digit;
        logic       do_finish;
        in_frame_next       = in_frame_reg;
        stored_count_next   = stored_count_reg;
        comma_count_next    = comma_count_reg;
        window_pos_next     = window_pos_reg;
        scaled_accum_next   = scaled_accum_reg;
        number_phase_next   = number_phase_reg;
        type_is_g_next      = type_is_g_reg;
        third_comma_ok_next = third_comma_ok_reg;
        pending_lat_next    = pending_lat_reg;
        pending_lon_next    = pending_lon_reg;
        pending_ns_next     = pending_ns_reg;
        pending_ew_next     = pending_ew_reg;
        held_lat_next       = held_lat_reg;
        held_lon_next       = held_lon_reg;
        held_ns_next        = held_ns_reg;
        held_ew_next        = held_ew_reg;
        emit                = 1'b0;
        fix_valid_now       = 1'b0;
        digit               = rx_byte_reg[3:0];
        is_digit            = (rx_byte_reg >= CHR_ZERO) && (rx_byte_reg <= CHR_NINE);
        do_finish           = 1'b0;

        if (byte_valid_reg) begin
            if (rx_byte_reg == CHR_DOLLAR) begin
                // Open a new frame and drop whatever was collected
                in_frame_next       = 1'b1;
                stored_count_next   = '0;
                comma_count_next    = '0;
                window_pos_next     = '0;
                scaled_accum_next   = '0;
                number_phase_next   = PHASE_INT;
                type_is_g_next      = 1'b0;
                third_comma_ok_next = 1'b0;
                pending_lat_next    = '0;
                pending_lon_next    = '0;
                pending_ns_next     = '0;
                pending_ew_next     = '0;
            end else if (in_frame_reg) begin
                if (rx_byte_reg != CHR_NEWLINE) begin
                    if (stored_count_reg < CNT_W'(BUFFER_BYTES - 1)) begin
                        if (stored_count_reg == CNT_W'(TYPE_CHAR_POS)) begin
                            type_is_g_next = (rx_byte_reg == CHR_G);
                        end

                        if (comma_count_reg == COMMA_LAT || comma_count_reg == COMMA_LON) begin
                            // Read one character of the number window
                            if (number_phase_reg != PHASE_DONE &&
                                window_pos_reg < WINDOW_LEN) begin
                                if (is_digit) begin
                                    if (number_phase_reg == PHASE_INT) begin
                                        scaled_accum_next = times_ten(scaled_accum_reg) +
                                            COORD_W'(digit_weight(digit, 3'(FRAC_DIGITS)));
                                    end else if (number_phase_reg <= FRAC_DIGITS) begin
                                        scaled_accum_next = scaled_accum_reg +
                                            COORD_W'(digit_weight(digit,
                                                3'(FRAC_DIGITS - number_phase_reg)));
                                        number_phase_next = number_phase_reg + 4'd1;
                                    end
                                end else if (rx_byte_reg == CHR_POINT &&
                                             number_phase_reg == PHASE_INT) begin
                                    number_phase_next = PHASE_FRAC;
                                end else begin
                                    do_finish = 1'b1;
                                end
                                window_pos_next = window_pos_reg + 4'd1;
                                if (window_pos_next >= WINDOW_LEN) begin
                                    do_finish = 1'b1;
                                end
                                if (do_finish) begin
                                    number_phase_next = PHASE_DONE;
                                    if (comma_count_reg == COMMA_LAT) begin
                                        pending_lat_next = scaled_accum_next;
                                    end else begin
                                        pending_lon_next = scaled_accum_next;
                                    end
                                end
                            end
                        end else if ((comma_count_reg == COMMA_NS ||
                                      comma_count_reg == COMMA_EW) &&
                                     window_pos_reg == 4'd0) begin
                            // Take the hemisphere character
                            if (comma_count_reg == COMMA_NS) begin
                                pending_ns_next = rx_byte_reg;
                            end else begin
                                pending_ew_next = rx_byte_reg;
                            end
                            window_pos_next = 4'd1;
                        end

                        // Advance to the next field on a comma
                        if (rx_byte_reg == CHR_COMMA && comma_count_reg < COMMA_MAX) begin
                            comma_count_next = comma_count_reg + 3'd1;
                            if (comma_count_next == COMMA_NS) begin
                                third_comma_ok_next =
                                    (stored_count_reg >= CNT_W'(THIRD_COMMA_MIN));
                            end
                            window_pos_next   = '0;
                            number_phase_next = PHASE_INT;
                            scaled_accum_next = '0;
                        end

                        stored_count_next = stored_count_reg + 1'b1;
                    end
                end else begin
                    // Close the frame and report a GGA line
                    in_frame_next = 1'b0;
                    if (type_is_g_reg) begin
                        emit = 1'b1;
                        if (comma_count_reg >= COMMA_NS && third_comma_ok_reg) begin
                            if (comma_count_reg == COMMA_LON &&
                                number_phase_reg != PHASE_DONE) begin
                                number_phase_next = PHASE_DONE;
                                pending_lon_next  = scaled_accum_reg;
                            end
                            held_lat_next = pending_lat_reg;
                            held_lon_next = pending_lon_next;
                            held_ns_next  = pending_ns_reg;
                            held_ew_next  = pending_ew_reg;
                            fix_valid_now = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Load the byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_ready) begin
            byte_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            rx_byte_reg <= s_rx_byte;
        end
    end

    // Update the frame state when the byte moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg       <= 1'b0;
            stored_count_reg   <= '0;
            comma_count_reg    <= '0;
            window_pos_reg     <= '0;
            scaled_accum_reg   <= '0;
            number_phase_reg   <= PHASE_INT;
            type_is_g_reg      <= 1'b0;
            third_comma_ok_reg <= 1'b0;
            pending_lat_reg    <= '0;
            pending_lon_reg    <= '0;
            pending_ns_reg     <= '0;
            pending_ew_reg     <= '0;
            held_lat_reg       <= HELD_LAT_RST;
            held_lon_reg       <= HELD_LON_RST;
            held_ns_reg        <= HELD_NS_RST;
            held_ew_reg        <= HELD_EW_RST;
        end else if (advance) begin
            in_frame_reg       <= in_frame_next;
            stored_count_reg   <= stored_count_next;
            comma_count_reg    <= comma_count_next;
            window_pos_reg     <= window_pos_next;
            scaled_accum_reg   <= scaled_accum_next;
            number_phase_reg   <= number_phase_next;
            type_is_g_reg      <= type_is_g_next;
            third_comma_ok_reg <= third_comma_ok_next;
            pending_lat_reg    <= pending_lat_next;
            pending_lon_reg    <= pending_lon_next;
            pending_ns_reg     <= pending_ns_next;
            pending_ew_reg     <= pending_ew_next;
            held_lat_reg       <= held_lat_next;
            held_lon_reg       <= held_lon_next;
            held_ns_reg        <= held_ns_next;
            held_ew_reg        <= held_ew_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            fix_valid_reg <= fix_valid_now;
            lat_out_reg   <= held_lat_next;
            lon_out_reg   <= held_lon_next;
            ns_out_reg    <= held_ns_next;
            ew_out_reg    <= held_ew_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fix_valid       = fix_valid_reg;
    assign m_latitude_micro  = lat_out_reg;
    assign m_longitude_micro = lon_out_reg;
    assign m_north_south     = ns_out_reg;
    assign m_east_west       = ew_out_reg;

    // Checks on the parse state and the stall path
    `ASSERT_HOLDS(a_third_ok_needs_comma, aclk, aresetn, (comma_count_reg >= COMMA_NS) || !third_comma_ok_reg, "third comma flag set before the third comma")
    `ASSERT_HOLDS(a_window_bound, aclk, aresetn, window_pos_reg <= WINDOW_LEN, "number window position past its end")
    `ASSERT_HOLDS(a_phase_legal, aclk, aresetn, (number_phase_reg <= (FRAC_DIGITS + 4'd1)) || (number_phase_reg == PHASE_DONE), "number phase out of range")
    `ASSERT_NEXT(a_stalled_byte_holds, aclk, aresetn, byte_valid_reg && !advance, byte_valid_reg && $stable(rx_byte_reg), "stalled word lost from byte register")

endmodule

// ----- tb/nmea_gga_position_parser_unit_tb.sv -----
// Self-checking testbench for the GGA position parser: directed lines, then random traffic.
module nmea_gga_position_parser_unit_tb;
    import ngga_pkg::*;

    localparam int BUFFER_BYTES = 128;
    localparam int KEEP_MAX     = BUFFER_BYTES - 1;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_SHOWN    = 10;
    localparam logic [7:0] CHR_CR = 8'h0D;

    // One position word as the block reports it
    typedef struct {
        logic       fix_ok;
        coord_t     lat;
        coord_t     lon;
        logic [7:0] ns;
        logic [7:0] ew;
    } gga_fix_t;

    // One directed line, with its word typed in where it is obvious
    typedef struct {
        string    text;
        bit       typed;
        gga_fix_t want;
    } gga_line_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_fix_valid;
    logic [COORD_W-1:0] m_latitude_micro;
    logic [COORD_W-1:0] m_longitude_micro;
    logic [7:0]         m_north_south;
    logic [7:0]         m_east_west;

    nmea_gga_position_parser_unit #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fix_valid       (m_fix_valid),
        .m_latitude_micro  (m_latitude_micro),
        .m_longitude_micro (m_longitude_micro),
        .m_north_south     (m_north_south),
        .m_east_west       (m_east_west)
    );

    // Parser state mirrored by the predictor
    bit         frame_open;
    int         kept;
    logic [2:0] comma_seen;
    logic [3:0] win_pos;
    coord_t     num_acc;
    logic [3:0] num_phase;
    bit         type_g;
    bit         comma3_ok;
    coord_t     next_lat;
    coord_t     next_lon;
    logic [7:0] next_ns;
    logic [7:0] next_ew;
    coord_t     held_lat = HELD_LAT_RST;
    coord_t     held_lon = HELD_LON_RST;
    logic [7:0] held_ns  = HELD_NS_RST;
    logic [7:0] held_ew  = HELD_EW_RST;

    // Expected position words, oldest first
    gga_fix_t   fix_q[$];
    gga_fix_t   typed_fix;
    bit         typed_next;
    gga_fix_t   seen_want;

    gga_line_t  rows[$];
    logic [7:0] line_q[$];

    bit hold_req = 1'b0;
    bit quiet    = 1'b0;
    int stall_left;
    int idle_cycles;
    int err_count;
    int bytes_sent;
    int results_made;
    int words_checked;
    int fixes_seen;
    int rejects_seen;

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Scale the number read so far to 10^4 and store it as latitude or longitude
    function automatic void close_number();
        logic [3:0]  frac;
        logic [15:0] scale;
        logic [63:0] prod;
        frac = (num_phase == PHASE_INT) ? 4'd0 : num_phase - PHASE_FRAC;
        if (frac > FRAC_DIGITS) frac = FRAC_DIGITS;
        case (frac)
            4'd0:    scale = 16'd10000;
            4'd1:    scale = 16'd1000;
            4'd2:    scale = 16'd100;
            4'd3:    scale = 16'd10;
            default: scale = 16'd1;
        endcase
        prod = 64'(num_acc) * 64'(scale);
        if (comma_seen == COMMA_LAT) next_lat = prod[COORD_W-1:0];
        else next_lon = prod[COORD_W-1:0];
        num_phase = PHASE_DONE;
    endfunction

    // Take one character of a coordinate window
    function automatic void read_digit(input logic [7:0] b);
        logic [63:0] acc10;
        if (num_phase == PHASE_DONE || win_pos >= WINDOW_LEN) return;
        acc10 = 64'(num_acc) * 64'd10 + 64'(b - CHR_ZERO);
        if (b >= CHR_ZERO && b <= CHR_NINE) begin
            if (num_phase == PHASE_INT) begin
                num_acc = acc10[COORD_W-1:0];
            end else if (num_phase <= FRAC_DIGITS) begin
                num_acc = acc10[COORD_W-1:0];
                num_phase = num_phase + 4'd1;
            end
        end else if (b == CHR_POINT && num_phase == PHASE_INT) begin
            num_phase = PHASE_FRAC;
        end else begin
            close_number();
        end
        win_pos = win_pos + 4'd1;
        if (win_pos >= WINDOW_LEN && num_phase != PHASE_DONE) close_number();
    endfunction

    // Scan one kept byte of the frame
    function automatic void keep_byte(input logic [7:0] b);
        if (kept == TYPE_CHAR_POS) type_g = (b == CHR_G);
        if (comma_seen == COMMA_LAT || comma_seen == COMMA_LON) begin
            read_digit(b);
        end else if ((comma_seen == COMMA_NS || comma_seen == COMMA_EW) && win_pos == 0) begin
            if (comma_seen == COMMA_NS) next_ns = b;
            else next_ew = b;
            win_pos = 4'd1;
        end
        if (b == CHR_COMMA && comma_seen < COMMA_MAX) begin
            comma_seen = comma_seen + 3'd1;
            if (comma_seen == COMMA_NS) comma3_ok = (kept >= THIRD_COMMA_MIN);
            win_pos   = 4'd0;
            num_phase = PHASE_INT;
            num_acc   = '0;
        end
        kept++;
    endfunction

    function automatic void clear_frame();
        kept       = 0;
        comma_seen = 3'd0;
        win_pos    = 4'd0;
        num_acc    = '0;
        num_phase  = PHASE_INT;
        type_g     = 1'b0;
        comma3_ok  = 1'b0;
        next_lat   = '0;
        next_lon   = '0;
        next_ns    = 8'h00;
        next_ew    = 8'h00;
    endfunction

    // Advance the predictor by one accepted byte; queue a word on a GGA newline.
    // Return 1 when the byte takes part in a frame.
    function automatic bit track_byte(input logic [7:0] b);
        gga_fix_t r;
        if (b == CHR_DOLLAR) begin
            frame_open = 1'b1;
            clear_frame();
            return 1'b1;
        end
        if (!frame_open) return 1'b0;
        if (b != CHR_NEWLINE) begin
            if (kept < KEEP_MAX) keep_byte(b);
            return 1'b1;
        end
        frame_open = 1'b0;
        if (!type_g) return 1'b1;
        r.fix_ok = 1'b0;
        if (comma_seen >= COMMA_NS && comma3_ok) begin
            if (comma_seen == COMMA_LON && num_phase != PHASE_DONE) close_number();
            held_lat = next_lat;
            held_lon = next_lon;
            held_ns  = next_ns;
            held_ew  = next_ew;
            r.fix_ok = 1'b1;
        end
        r.lat = held_lat;
        r.lon = held_lon;
        r.ns  = held_ns;
        r.ew  = held_ew;
        if (typed_next) r = typed_fix;
        typed_next = 1'b0;
        fix_q.push_back(r);
        results_made++;
        return 1'b1;
    endfunction

    task automatic add_row(input string t);
        gga_line_t row;
        row.text  = t;
        row.typed = 1'b0;
        row.want  = '{default: '0};
        rows.push_back(row);
    endtask

    task automatic add_typed_row(input string t, input logic ok, input coord_t lat,
                                 input coord_t lon, input logic [7:0] ns,
                                 input logic [7:0] ew);
        gga_line_t row;
        row.text  = t;
        row.typed = 1'b1;
        row.want  = '{fix_ok: ok, lat: lat, lon: lon, ns: ns, ew: ew};
        rows.push_back(row);
    endtask

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) line_q.push_back(t[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) line_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Append a coordinate field: digits, an optional point and fraction, rare junk
    task automatic push_number();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 11) : $urandom_range(2, 5);
        push_digits(n);
        if ($urandom_range(0, 5) != 0) begin
            line_q.push_back(CHR_POINT);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 5);
            push_digits(n);
        end
        if ($urandom_range(0, 15) == 0) line_q.push_back(8'($urandom_range(33, 126)));
    endtask

    // Append a hemisphere character, sometimes empty or arbitrary
    task automatic push_hemi(input bit clean, input logic [7:0] a, input logic [7:0] b);
        int n;
        n = $urandom_range(0, 15);
        if (clean || n > 3) line_q.push_back(n[0] ? a : b);
        else if (n != 0) line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Build one random sentence into line_q; broken and noisy unless clean
    task automatic make_sentence(input bit clean);
        int kind;
        int n;
        line_q.delete();
        line_q.push_back(CHR_DOLLAR);
        kind = clean ? 0 : $urandom_range(0, 9);
        if (kind < 7) push_text(($urandom_range(0, 1) != 0) ? "GPGGA" : "GNGGA");
        else if (kind == 7) push_text("GPRMC");
        else if (kind == 8) push_text("GPGSA");
        else repeat (5) line_q.push_back(8'($urandom_range(32, 126)));
        line_q.push_back(CHR_COMMA);
        // time field length moves the third comma across its lower bound
        push_digits($urandom_range(0, 12));
        line_q.push_back(CHR_COMMA);
        push_number();
        line_q.push_back(CHR_COMMA);
        push_hemi(clean, "N", "S");
        line_q.push_back(CHR_COMMA);
        push_number();
        line_q.push_back(CHR_COMMA);
        push_hemi(clean, "E", "W");
        case ($urandom_range(0, 4))
            1: push_text(",1,08,0.9,545.4,M,46.9,M,,*47");
            2: repeat ($urandom_range(1, 10)) line_q.push_back(CHR_COMMA);
            3: repeat ($urandom_range(60, 110)) line_q.push_back(8'($urandom_range(32, 126)));
            default: ;
        endcase
        if (!clean) begin
            // cut the line short, or corrupt one byte
            if ($urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, line_q.size());
                while (line_q.size() > n) void'(line_q.pop_back());
            end
            if ($urandom_range(0, 9) == 0 && line_q.size() > 1)
                line_q[$urandom_range(1, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) == 0) line_q.push_back(CHR_CR);
        if (clean || $urandom_range(0, 11) != 0) line_q.push_back(CHR_NEWLINE);
        if (!clean && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Offer one word from a falling edge and hold it until accepted
    task automatic push_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (track_byte(b)) bytes_sent++;
        @(negedge aclk);
    endtask

    // Send line_q, with random sender gaps unless in a quiet or pressure stretch
    task automatic send_line();
        foreach (line_q[i]) begin
            if (!quiet && !hold_req && $urandom_range(0, 24) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            push_byte(line_q[i]);
        end
    endtask

    task automatic send_random_until(input int byte_goal, input int word_goal);
        while (bytes_sent < byte_goal || results_made < word_goal) begin
            make_sentence($urandom_range(0, 2) != 0);
            send_line();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        err_count++;
        if (err_count <= MAX_SHOWN)
            $display("mismatch %0d: %s expected %0d got %0d at %0t",
                     err_count, what, want, got, $realtime);
    endtask

    // Receiver: random stall bursts, one long hold on request, none when quiet
    initial begin
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 18);
            end
        end
    end

    // Compare each accepted position word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (fix_q.size() == 0) begin
                flag_mismatch("position word with none expected, fix_valid", 0, m_fix_valid);
            end else begin
                seen_want = fix_q.pop_front();
                if (m_fix_valid !== seen_want.fix_ok)
                    flag_mismatch("fix_valid", seen_want.fix_ok, m_fix_valid);
                if (m_latitude_micro !== seen_want.lat)
                    flag_mismatch("latitude_micro", seen_want.lat, m_latitude_micro);
                if (m_longitude_micro !== seen_want.lon)
                    flag_mismatch("longitude_micro", seen_want.lon, m_longitude_micro);
                if (m_north_south !== seen_want.ns)
                    flag_mismatch("north_south", seen_want.ns, m_north_south);
                if (m_east_west !== seen_want.ew)
                    flag_mismatch("east_west", seen_want.ew, m_east_west);
                words_checked++;
                if (seen_want.fix_ok) fixes_seen++;
                else rejects_seen++;
            end
        end
    end

    // Drop the run when nothing moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        string long_line;
        int    random_base;

        clear_frame();
        frame_open = 1'b0;
        typed_next = 1'b0;

        // after reset: third comma too early, default position comes back
        add_typed_row("$GPGGA,1,2,N,3,E\n", 1'b0, HELD_LAT_RST, HELD_LON_RST,
                      HELD_NS_RST, HELD_EW_RST);
        // largest coordinates: full windows of nines
        add_typed_row("$GPGGA,123519.00,999999999,S,999999999,W\n", 1'b1,
                      44'd9999999990000, 44'd9999999990000, "S", "W");
        // third comma at the lowest accepted index, empty coordinates read as zero
        add_typed_row("$GPGGA,0000000000,,N,,E\n", 1'b1, '0, '0, "N", "E");
        // third comma one byte too early: rejected, held values stay
        add_typed_row("$GPGGA,000000000,,N,,E\n", 1'b0, '0, '0, "N", "E");
        add_row("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        // fraction digits beyond four are truncated
        add_row("$GPGGA,123519,1.2345678,S,.99999,W\n");
        // lone point, second point
        add_row("$GPGGA,123519,.,N,12.3.4,E\n");
        // sign and letters stop the reading
        add_row("$GPGGA,123519,-4807.5,N,48a07,E\n");
        // digits running past the window
        add_row("$GPGGA,123519,12345678901,N,123456789.5,E\n");
        // missing fourth comma, then missing fifth with longitude cut by the newline
        add_row("$GPGGA,123519,4807.038,N\n");
        add_row("$GPGGA,123519,4807.038,S,0113\n");
        // empty hemispheres take the comma itself, none at the end of line
        add_row("$GPGGA,123519,4807.038,,01131.0,,1\n");
        add_row("$GPGGA,123519,4807.038,N,01131.0,\n");
        // no third comma
        add_row("$GPGGA,123519123519123519,4807\n");
        // dollar inside a frame restarts it
        add_row("$GPGGA,1234$GPGGA,123519,4807.5,N,01131.5,E\n");
        // bytes and newlines outside a frame, short frames
        add_row("noise\n,G,\n$GP\n$GPG\n");
        add_row("$GPGG\n");
        // other sentence types give nothing
        add_row("$GPRMC,123519,A,4807.038,N,01131.000,E\n");
        add_row("$GPGSA,123519,4807.038,N,01131.000,E\n");
        // longitude window cut off by the end of the buffer
        long_line = "$GPGGA,";
        repeat (95) long_line = {long_line, "Z"};
        long_line = {long_line, "123519,4807.038,N,01131.000,E,1,2,3\n"};
        add_row(long_line);

        // hold reset, then release it from a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed lines
        foreach (rows[i]) begin
            line_q.delete();
            push_text(rows[i].text);
            typed_next = rows[i].typed;
            typed_fix  = rows[i].want;
            send_line();
            typed_next = 1'b0;
        end

        // random traffic with idling on both sides
        random_base = results_made;
        send_random_until(1000, 0);

        // hold the receiver off while sentences keep coming, then drain
        hold_req = 1'b1;
        while (hold_req) begin
            make_sentence(1'b1);
            send_line();
        end
        s_valid <= 1'b0;
        while (fix_q.size() != 0) @(posedge aclk);
        @(negedge aclk);

        send_random_until(1450, 0);

        // last stretch without idling
        quiet = 1'b1;
        send_random_until(1750, random_base + 8);

        // wait for the last words, then watch for strays before the summary
        s_valid <= 1'b0;
        while (fix_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("tb summary: %0d frame bytes (%0d directed lines plus random traffic)",
                 bytes_sent, rows.size());
        $display("tb summary: %0d position words checked, %0d fixes, %0d rejects, %0d errors",
                 words_checked, fixes_seen, rejects_seen, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ngga_pkg.sv
rtl/core/nmea_gga_position_parser_unit.sv
tb/nmea_gga_position_parser_unit_tb.sv
